// ===== src/hpgl_line_command_parser_core_assert.svh =====
// Assertion macros for the HPGL line command parser checker.
// Pulled in by the checker with a plain include; no other dependencies.
`ifndef HPGL_LINE_COMMAND_PARSER_CORE_ASSERT_SVH
`define HPGL_LINE_COMMAND_PARSER_CORE_ASSERT_SVH

// Condition in one cycle implies a consequence in the next, outside reset.
`define HLCP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

// Consequence that must hold in the cycle after reset is applied.
`define HLCP_ASSERT_AFTER_RESET(lbl, clk_s, rst_s, cons, msg) \
  lbl: assert property (@(posedge clk_s) (rst_s) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hlcp_pkg.sv =====
// Shared types for the HPGL line command parser.
// Used by the front classifier, the queue and the back parser.
package hlcp_pkg;

  // Character class of one stream byte, as seen by the parser.
  typedef struct packed {
    logic       eos;
    logic       term;
    logic       newline;
    logic       ws;
    logic       digit;
    logic       digit_hi;
    logic       sign;
    logic       minus;
    logic       dot;
    logic       comma;
    logic       letter_p;
    logic       cmd_a;
    logic       cmd_r;
    logic       cmd_u;
    logic       cmd_d;
    logic [3:0] digit_val;
  } char_class_t;

endpackage

// ===== src/hlcp_front.sv =====
// Front end: takes stream bytes and classifies them for the parser.
// Depends on hlcp_pkg for the character class type.
module hlcp_front (
  input  logic                 byte_valid,
  input  logic [7:0]           byte_in,
  input  logic                 end_of_stream,
  input  logic                 queue_full,
  output logic                 byte_stall,
  output logic                 push,
  output hlcp_pkg::char_class_t cls
);
  import hlcp_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_U     = 8'h55;

  // Hold the stream while the queue has no room.
  assign byte_stall = queue_full;
  assign push       = byte_valid && !queue_full;

  // Classify the byte; end of stream is a terminator and nothing else.
  always_comb begin
    cls = '0;
    if (end_of_stream) begin
      cls.eos  = 1'b1;
      cls.term = 1'b1;
    end else begin
      cls.term      = (byte_in == CH_SEMI) || (byte_in == CH_LF);
      cls.newline   = (byte_in == CH_LF);
      cls.ws        = byte_in inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
      cls.digit     = byte_in inside {[CH_0:CH_9]};
      cls.digit_hi  = byte_in inside {[CH_5:CH_9]};
      cls.sign      = (byte_in == CH_PLUS) || (byte_in == CH_MINUS);
      cls.minus     = (byte_in == CH_MINUS);
      cls.dot       = (byte_in == CH_DOT);
      cls.comma     = (byte_in == CH_COMMA);
      cls.letter_p  = (byte_in == CH_P);
      cls.cmd_a     = (byte_in == CH_A);
      cls.cmd_r     = (byte_in == CH_R);
      cls.cmd_u     = (byte_in == CH_U);
      cls.cmd_d     = (byte_in == CH_D);
      cls.digit_val = byte_in[3:0];
    end
  end

endmodule

// ===== src/hlcp_queue.sv =====
// Short queue of classified bytes between front end and parser.
// Depends on hlcp_pkg for the entry type.
module hlcp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  hlcp_pkg::char_class_t wr_item,
  output logic                  full,
  output logic                  rd_valid,
  output hlcp_pkg::char_class_t rd_item,
  input  logic                  pop
);
  import hlcp_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  char_class_t     entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign full     = (count == (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];

  // Store pushed entries.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/hlcp_back.sv =====
// Back end: command and number parser, position update and segment output.
// Depends on hlcp_pkg for the character class type.
module hlcp_back #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cls_valid,
  input  hlcp_pkg::char_class_t cls,
  output logic                  cls_pop,
  output logic                  seg_valid,
  input  logic                  seg_stall,
  output logic signed [31:0]    seg_start_x,
  output logic signed [31:0]    seg_start_y,
  output logic signed [31:0]    seg_end_x,
  output logic signed [31:0]    seg_end_y
);
  import hlcp_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam logic [CW-1:0]        MAG_CAP   = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [3:0] {
    PH_CMD1 = 4'b0001,
    PH_CMD2 = 4'b0010,
    PH_SKIP = 4'b0100,
    PH_NUM  = 4'b1000
  } phase_t;

  typedef enum logic [5:0] {
    SUB_WS   = 6'b000001,
    SUB_SIGN = 6'b000010,
    SUB_INT  = 6'b000100,
    SUB_DOT0 = 6'b001000,
    SUB_DOTD = 6'b010000,
    SUB_FRAC = 6'b100000
  } sub_t;

  phase_t phase, phase_next;
  sub_t   sub, sub_next;
  logic   num_is_y, num_is_y_next;
  logic   first_p, first_p_next;
  logic   pen_down, pen_down_next;
  logic   absolute_mode, absolute_mode_next;
  logic [CW-1:0]        number_accum, number_accum_next;
  logic                 number_negative, number_negative_next;
  logic                 round_up_pending, round_up_pending_next;
  logic signed [CW-1:0] held_x, held_x_next;
  logic signed [CW-1:0] pos_x, pos_y;

  // Pending pair completion, registered when the pair is parsed and carried out once its segment can go.
  logic                 calc_valid;
  logic signed [CW-1:0] calc_x, calc_y;
  logic                 calc_abs, calc_pen, calc_eos;
  logic                 calc_fire;
  logic                 launch;

  logic num_done, num_fail;
  logic [CW+3:0]        acc_prod;
  logic [CW-1:0]        acc_sum;
  logic [CW-1:0]        rnd_mag;
  logic signed [CW-1:0] num_value;
  logic signed [CW-1:0] end_x, end_y;

  function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) begin
      return s[CW] ? COORD_MIN : COORD_MAX;
    end
    return s[CW-1:0];
  endfunction

  // Multiply-by-ten accumulate, saturating at the magnitude cap.
  always_comb begin
    acc_prod = ({4'b0000, number_accum} << 3) + ({4'b0000, number_accum} << 1)
             + (CW+4)'(cls.digit_val);
    acc_sum  = (acc_prod > (CW+4)'(MAG_CAP)) ? MAG_CAP : acc_prod[CW-1:0];
  end

  // Round half away from zero, apply sign and clamp to the coordinate range.
  always_comb begin
    rnd_mag = number_accum + CW'(round_up_pending && !number_accum[CW-1]);
    if (number_negative) begin
      num_value = rnd_mag[CW-1] ? COORD_MIN : -$signed(rnd_mag);
    end else begin
      num_value = rnd_mag[CW-1] ? COORD_MAX : $signed(rnd_mag);
    end
  end

  // Complete a pending pair unless its segment has nowhere to go.
  assign calc_fire = calc_valid && (!calc_pen || !seg_valid || !seg_stall);
  assign cls_pop   = cls_valid && !(calc_valid && !calc_fire);
  assign end_x     = calc_abs ? calc_x : sat_add(pos_x, calc_x);
  assign end_y     = calc_abs ? calc_y : sat_add(pos_y, calc_y);

  // Parser transition for one popped byte.
  always_comb begin
    phase_next            = phase;
    sub_next              = sub;
    num_is_y_next         = num_is_y;
    first_p_next          = first_p;
    pen_down_next         = pen_down;
    absolute_mode_next    = absolute_mode;
    number_accum_next     = number_accum;
    number_negative_next  = number_negative;
    round_up_pending_next = round_up_pending;
    held_x_next           = held_x;
    launch                = 1'b0;
    num_done              = 1'b0;
    num_fail              = 1'b0;
    if (cls_pop) begin
      case (phase)
        PH_CMD2: begin
          if (cls.newline || cls.eos) begin
            phase_next = PH_SKIP;
          end else if (first_p && (cls.cmd_a || cls.cmd_r || cls.cmd_u || cls.cmd_d)) begin
            if (cls.cmd_a) begin
              absolute_mode_next = 1'b1;
            end else if (cls.cmd_r) begin
              absolute_mode_next = 1'b0;
            end else if (cls.cmd_u) begin
              pen_down_next = 1'b0;
            end else begin
              pen_down_next = 1'b1;
            end
            number_accum_next     = '0;
            number_negative_next  = 1'b0;
            round_up_pending_next = 1'b0;
            phase_next            = PH_NUM;
            sub_next              = SUB_WS;
            num_is_y_next         = 1'b0;
          end else begin
            phase_next = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (cls.term) begin
            phase_next = PH_CMD1;
          end
        end
        PH_NUM: begin
          case (sub)
            SUB_WS: begin
              if (cls.sign) begin
                number_negative_next = cls.minus;
                sub_next             = SUB_SIGN;
              end else if (cls.digit) begin
                number_accum_next = acc_sum;
                sub_next          = SUB_INT;
              end else if (cls.dot) begin
                sub_next = SUB_DOT0;
              end else if (!cls.ws) begin
                num_fail = 1'b1;
              end
            end
            SUB_SIGN: begin
              if (cls.digit) begin
                number_accum_next = acc_sum;
                sub_next          = SUB_INT;
              end else if (cls.dot) begin
                sub_next = SUB_DOT0;
              end else begin
                num_fail = 1'b1;
              end
            end
            SUB_INT: begin
              if (cls.digit) begin
                number_accum_next = acc_sum;
              end else if (cls.dot) begin
                sub_next = SUB_DOTD;
              end else begin
                num_done = 1'b1;
              end
            end
            SUB_DOT0, SUB_DOTD: begin
              if (cls.digit) begin
                round_up_pending_next = cls.digit_hi;
                sub_next              = SUB_FRAC;
              end else if (sub == SUB_DOT0) begin
                num_fail = 1'b1;
              end else begin
                num_done = 1'b1;
              end
            end
            SUB_FRAC: begin
              if (!cls.digit) begin
                num_done = 1'b1;
              end
            end
            default: begin
              num_fail = 1'b1;
            end
          endcase
          if (num_fail) begin
            phase_next = cls.term ? PH_CMD1 : PH_SKIP;
          end else if (num_done) begin
            number_accum_next     = '0;
            number_negative_next  = 1'b0;
            round_up_pending_next = 1'b0;
            if (!num_is_y) begin
              held_x_next = num_value;
              if (cls.comma) begin
                num_is_y_next = 1'b1;
                sub_next      = SUB_WS;
              end else begin
                phase_next = cls.term ? PH_CMD1 : PH_SKIP;
              end
            end else begin
              launch = 1'b1;
              if (cls.term) begin
                phase_next = PH_CMD1;
              end else begin
                sub_next      = SUB_WS;
                num_is_y_next = 1'b0;
              end
            end
          end
        end
        default: begin
          // first letter of a command token
          if (cls.newline) begin
            phase_next = PH_SKIP;
          end else if (!cls.eos) begin
            first_p_next = cls.letter_p;
            phase_next   = PH_CMD2;
          end
        end
      endcase
      // End of stream drops all parser state once the byte has acted.
      if (cls.eos) begin
        phase_next            = PH_CMD1;
        sub_next              = SUB_WS;
        num_is_y_next         = 1'b0;
        first_p_next          = 1'b0;
        pen_down_next         = 1'b0;
        absolute_mode_next    = 1'b0;
        number_accum_next     = '0;
        number_negative_next  = 1'b0;
        round_up_pending_next = 1'b0;
        held_x_next           = '0;
      end
    end
  end

  // Parser, position and output control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_CMD1;
      sub              <= SUB_WS;
      num_is_y         <= 1'b0;
      first_p          <= 1'b0;
      pen_down         <= 1'b0;
      absolute_mode    <= 1'b0;
      number_accum     <= '0;
      number_negative  <= 1'b0;
      round_up_pending <= 1'b0;
      held_x           <= '0;
      calc_valid       <= 1'b0;
      pos_x            <= '0;
      pos_y            <= '0;
      seg_valid        <= 1'b0;
    end else begin
      phase            <= phase_next;
      sub              <= sub_next;
      num_is_y         <= num_is_y_next;
      first_p          <= first_p_next;
      pen_down         <= pen_down_next;
      absolute_mode    <= absolute_mode_next;
      number_accum     <= number_accum_next;
      number_negative  <= number_negative_next;
      round_up_pending <= round_up_pending_next;
      held_x           <= held_x_next;
      if (launch) begin
        calc_valid <= 1'b1;
      end else if (calc_fire) begin
        calc_valid <= 1'b0;
      end
      // End of stream with no pair of its own clears the position after any
      // older pair; a pair that it completes clears it once that pair has moved.
      if (cls_pop && cls.eos && !launch) begin
        pos_x <= '0;
        pos_y <= '0;
      end else if (calc_fire) begin
        pos_x <= calc_eos ? '0 : end_x;
        pos_y <= calc_eos ? '0 : end_y;
      end
      if (calc_fire && calc_pen) begin
        seg_valid <= 1'b1;
      end else if (!seg_stall) begin
        seg_valid <= 1'b0;
      end
    end
  end

  // Capture a completed pair and load the segment payload.
  always_ff @(posedge clk) begin
    if (launch) begin
      calc_x   <= held_x;
      calc_y   <= num_value;
      calc_abs <= absolute_mode;
      calc_pen <= pen_down;
      calc_eos <= cls.eos;
    end
    if (calc_fire && calc_pen) begin
      seg_start_x <= 32'(pos_x);
      seg_start_y <= 32'(pos_y);
      seg_end_x   <= 32'(end_x);
      seg_end_y   <= 32'(end_y);
    end
  end

endmodule

// ===== src/hpgl_line_command_parser_core.sv =====
// HPGL line command parser. Takes one stream byte per cycle while the queue has
// room: the byte is classified on entry and written to a four-entry queue, and
// the parser pops one entry per clock unless it holds. The byte that completes a
// pair loads the pending pair registers as it leaves the queue, and the segment
// is then registered at the output. The parser holds only when a pen-down pair
// completes while an earlier segment still waits at the output; stall on the byte
// side rises once the queue fills. Coordinates are COORD_WIDTH-bit integer
// plotter units, saturating, and the segment ports carry their low 32 bits.
// Depends on hlcp_pkg, hlcp_front, hlcp_queue and hlcp_back.
module hpgl_line_command_parser_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         byte_in,
  input  logic               end_of_stream,
  output logic               seg_valid,
  input  logic               seg_stall,
  output logic signed [31:0] seg_start_x,
  output logic signed [31:0] seg_start_y,
  output logic signed [31:0] seg_end_x,
  output logic signed [31:0] seg_end_y
);
  import hlcp_pkg::*;

  char_class_t in_cls;
  char_class_t head_cls;
  logic        push;
  logic        queue_full;
  logic        head_valid;
  logic        head_pop;

  // Classify incoming bytes.
  hlcp_front u_front (
    .byte_valid    (byte_valid),
    .byte_in       (byte_in),
    .end_of_stream (end_of_stream),
    .queue_full    (queue_full),
    .byte_stall    (byte_stall),
    .push          (push),
    .cls           (in_cls)
  );

  // Decouple front end from parser.
  hlcp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_item  (in_cls),
    .full     (queue_full),
    .rd_valid (head_valid),
    .rd_item  (head_cls),
    .pop      (head_pop)
  );

  // Parse and emit segments.
  hlcp_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cls_valid   (head_valid),
    .cls         (head_cls),
    .cls_pop     (head_pop),
    .seg_valid   (seg_valid),
    .seg_stall   (seg_stall),
    .seg_start_x (seg_start_x),
    .seg_start_y (seg_start_y),
    .seg_end_x   (seg_end_x),
    .seg_end_y   (seg_end_y)
  );

endmodule

// ===== src/hlcp_checker.sv =====
// Port-level checks for the HPGL line command parser, bound to the top level.
// Depends on hpgl_line_command_parser_core_assert.svh for the assertion macros.
`include "hpgl_line_command_parser_core_assert.svh"

module hlcp_checker (
  input logic               clk,
  input logic               rst,
  input logic               byte_stall,
  input logic               seg_valid,
  input logic               seg_stall,
  input logic signed [31:0] seg_start_x,
  input logic signed [31:0] seg_start_y,
  input logic signed [31:0] seg_end_x,
  input logic signed [31:0] seg_end_y
);

  // A stalled segment stays offered.
  `HLCP_ASSERT_NEXT(a_seg_hold, clk, rst, seg_valid && seg_stall, seg_valid, "segment dropped while stalled")

  // A stalled segment keeps its coordinates.
  `HLCP_ASSERT_NEXT(a_seg_stable, clk, rst, seg_valid && seg_stall, $stable(seg_start_x) && $stable(seg_start_y) && $stable(seg_end_x) && $stable(seg_end_y), "segment changed while stalled")

  // Reset leaves no segment pending.
  `HLCP_ASSERT_AFTER_RESET(a_rst_no_seg, clk, rst, !seg_valid, "segment offered after reset")

  // Reset empties the queue, so bytes are taken at once.
  `HLCP_ASSERT_AFTER_RESET(a_rst_ready, clk, rst, !byte_stall, "byte side stalled after reset")

endmodule

bind hpgl_line_command_parser_core hlcp_checker u_hlcp_checker (
  .clk           (clk),
  .rst           (rst),
  .byte_stall    (byte_stall),
  .seg_valid     (seg_valid),
  .seg_stall     (seg_stall),
  .seg_start_x   (seg_start_x),
  .seg_start_y   (seg_start_y),
  .seg_end_x     (seg_end_x),
  .seg_end_y     (seg_end_y)
);

// ===== test/hpgl_line_command_parser_core_checker.sv =====
// Segment checker for the HPGL line command parser: watches both channels,
// predicts the segments that each accepted byte causes and compares them.
// Standalone; needs only the ports of hpgl_line_command_parser_core.
module hpgl_line_command_parser_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  logic               byte_stall,
  input  logic [7:0]         byte_in,
  input  logic               end_of_stream,
  input  logic               seg_valid,
  input  logic               seg_stall,
  input  logic signed [31:0] seg_start_x,
  input  logic signed [31:0] seg_start_y,
  input  logic signed [31:0] seg_end_x,
  input  logic signed [31:0] seg_end_y,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 32;
  localparam longint unsigned MAG_CAP = 64'd1 << (COORD_BITS - 1);
  localparam longint COORD_MAX = longint'(MAG_CAP - 1);
  localparam longint COORD_MIN = -COORD_MAX - 1;

  // Character codes; end of stream sits outside the byte range
  localparam int CHAR_EOS = 256;
  localparam int CH_NL    = 8'h0A;
  localparam int CH_SEMI  = ";";
  localparam int CH_COMMA = ",";
  localparam int CH_DOT   = ".";
  localparam int CH_PLUS  = "+";
  localparam int CH_MINUS = "-";
  localparam int CH_ZERO  = "0";
  localparam int CH_NINE  = "9";
  localparam int CH_FIVE  = "5";
  localparam int CH_P     = "P";
  localparam int CH_A     = "A";
  localparam int CH_R     = "R";
  localparam int CH_U     = "U";
  localparam int CH_D     = "D";

  typedef enum logic [1:0] {PH_CMD_FIRST, PH_CMD_SECOND, PH_DISCARD, PH_NUMBER} phase_e;
  typedef enum logic [2:0] {
    NUM_SPACE, NUM_SIGN, NUM_INT, NUM_DOT_LEAD, NUM_DOT_AFTER, NUM_FRAC
  } num_e;
  typedef enum logic [1:0] {STEP_MORE, STEP_DONE, STEP_BAD} step_e;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
  } seg_t;

  // Parser state
  phase_e          phase;
  num_e            sub;
  bit              reading_y;
  int              lead_char;
  bit              pen;
  bit              absolute;
  longint          cur_x, cur_y, held_x;
  longint unsigned mag;
  bit              neg;
  bit              round_up;

  seg_t segments_due[$];

  function automatic bit is_term(input int c);
    return c == CH_SEMI || c == CH_NL || c == CHAR_EOS;
  endfunction

  function automatic bit is_space(input int c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_digit(input int c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void clear_num();
    mag      = 0;
    neg      = 1'b0;
    round_up = 1'b0;
  endfunction

  function automatic void reset_parser();
    phase     = PH_CMD_FIRST;
    sub       = NUM_SPACE;
    reading_y = 1'b0;
    lead_char = 0;
    pen       = 1'b0;
    absolute  = 1'b0;
    cur_x     = 0;
    cur_y     = 0;
    held_x    = 0;
    clear_num();
  endfunction

  function automatic void start_number(input bit y);
    phase     = PH_NUMBER;
    reading_y = y;
    sub       = NUM_SPACE;
  endfunction

  // Drop the command; a terminator ends the drop at once
  function automatic void abandon(input int c);
    phase = is_term(c) ? PH_CMD_FIRST : PH_DISCARD;
  endfunction

  // Multiply-accumulate one digit, saturating at the magnitude cap
  function automatic void add_digit(input int c);
    longint unsigned d;
    d = longint'(c - CH_ZERO);
    if (mag > (MAG_CAP - d) / 10) mag = MAG_CAP;
    else mag = mag * 10 + d;
  endfunction

  function automatic longint num_value();
    longint unsigned m;
    m = mag;
    if (round_up && m < MAG_CAP) m++;
    if (neg) return (m >= MAG_CAP) ? COORD_MIN : -longint'(m);
    return (m > COORD_MAX) ? COORD_MAX : longint'(m);
  endfunction

  function automatic longint sat_add(input longint a, input longint b);
    if (b > 0 && a > COORD_MAX - b) return COORD_MAX;
    if (b < 0 && a < COORD_MIN - b) return COORD_MIN;
    return a + b;
  endfunction

  // Advance the number scanner by one character
  function automatic step_e number_advance(input int c);
    case (sub)
      NUM_SPACE: begin
        if (is_space(c)) return STEP_MORE;
        if (c == CH_PLUS || c == CH_MINUS) begin
          neg = (c == CH_MINUS);
          sub = NUM_SIGN;
          return STEP_MORE;
        end
        if (is_digit(c)) begin
          add_digit(c);
          sub = NUM_INT;
          return STEP_MORE;
        end
        if (c == CH_DOT) begin
          sub = NUM_DOT_LEAD;
          return STEP_MORE;
        end
        return STEP_BAD;
      end
      NUM_SIGN: begin
        if (is_digit(c)) begin
          add_digit(c);
          sub = NUM_INT;
          return STEP_MORE;
        end
        if (c == CH_DOT) begin
          sub = NUM_DOT_LEAD;
          return STEP_MORE;
        end
        return STEP_BAD;
      end
      NUM_INT: begin
        if (is_digit(c)) begin
          add_digit(c);
          return STEP_MORE;
        end
        if (c == CH_DOT) begin
          sub = NUM_DOT_AFTER;
          return STEP_MORE;
        end
        return STEP_DONE;
      end
      NUM_DOT_LEAD, NUM_DOT_AFTER: begin
        if (is_digit(c)) begin
          round_up = (c >= CH_FIVE);
          sub = NUM_FRAC;
          return STEP_MORE;
        end
        return (sub == NUM_DOT_LEAD) ? STEP_BAD : STEP_DONE;
      end
      default: return is_digit(c) ? STEP_MORE : STEP_DONE;
    endcase
  endfunction

  // Consume one character; return 1 with the segment when a pen-down pair completes
  function automatic bit parse_byte(input int c, output seg_t seg);
    step_e  r;
    longint yv, nx, ny;
    parse_byte = 1'b0;
    seg = '0;
    case (phase)
      PH_CMD_SECOND: begin
        if (c == CH_NL || c == CHAR_EOS) begin
          phase = PH_DISCARD;
        end else if (lead_char == CH_P &&
                     (c == CH_A || c == CH_R || c == CH_U || c == CH_D)) begin
          case (c)
            CH_A:    absolute = 1'b1;
            CH_R:    absolute = 1'b0;
            CH_U:    pen = 1'b0;
            default: pen = 1'b1;
          endcase
          clear_num();
          start_number(1'b0);
        end else begin
          phase = PH_DISCARD;
        end
      end
      PH_DISCARD: begin
        if (is_term(c)) phase = PH_CMD_FIRST;
      end
      PH_NUMBER: begin
        r = number_advance(c);
        if (r == STEP_BAD) begin
          abandon(c);
        end else if (r == STEP_DONE && !reading_y) begin
          held_x = num_value();
          clear_num();
          if (c == CH_COMMA) start_number(1'b1);
          else abandon(c);
        end else if (r == STEP_DONE) begin
          yv = num_value();
          nx = absolute ? held_x : sat_add(cur_x, held_x);
          ny = absolute ? yv : sat_add(cur_y, yv);
          if (pen) begin
            seg.sx = cur_x[31:0];
            seg.sy = cur_y[31:0];
            seg.ex = nx[31:0];
            seg.ey = ny[31:0];
            parse_byte = 1'b1;
          end
          cur_x = nx;
          cur_y = ny;
          clear_num();
          if (is_term(c)) phase = PH_CMD_FIRST;
          else start_number(1'b0);
        end
      end
      default: begin
        if (c == CH_NL) begin
          phase = PH_DISCARD;
        end else if (c != CHAR_EOS) begin
          lead_char = c;
          phase = PH_CMD_SECOND;
        end
      end
    endcase
  endfunction

  function automatic void check_coord(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Predict on each byte transfer, compare on each segment transfer
  always @(posedge clk) begin : watch
    seg_t want;
    bit   made;
    if (rst) begin
      reset_parser();
      segments_due.delete();
    end else begin
      if (byte_valid && !byte_stall) begin
        made = parse_byte(end_of_stream ? CHAR_EOS : int'(byte_in), want);
        if (made) segments_due.push_back(want);
        if (end_of_stream) reset_parser();
      end
      if (seg_valid && !seg_stall) begin
        if (segments_due.size() == 0) begin
          $error("segment (%0d,%0d)-(%0d,%0d) with none expected",
                 seg_start_x, seg_start_y, seg_end_x, seg_end_y);
          fail_count++;
        end else begin
          want = segments_due.pop_front();
          check_coord("seg_start_x", want.sx, seg_start_x);
          check_coord("seg_start_y", want.sy, seg_start_y);
          check_coord("seg_end_x", want.ex, seg_end_x);
          check_coord("seg_end_y", want.ey, seg_end_y);
        end
      end
    end
    pending = segments_due.size();
  end

endmodule

// ===== test/tb_hpgl_line_command_parser_core.sv =====
// Testbench top for hpgl_line_command_parser_core: drives HPGL byte streams
// with bursty valid and a patterned segment stall, and gives the verdict.
// Depends on the block and on hpgl_line_command_parser_checker.
module tb_hpgl_line_command_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STREAM_ITEMS = 1700;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [7:0] CH_P     = "P";
  localparam logic [7:0] CH_A     = "A";
  localparam logic [7:0] CH_R     = "R";
  localparam logic [7:0] CH_U     = "U";
  localparam logic [7:0] CH_D     = "D";
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_ZERO  = "0";

  typedef enum logic [1:0] {CMD_PA, CMD_PR, CMD_PU, CMD_PD} cmd_e;
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_ALTERNATE} rx_mode_e;

  logic               clk;
  logic               rst = 1'b1;
  logic               byte_valid = 1'b0;
  logic               byte_stall;
  logic [7:0]         byte_in = '0;
  logic               end_of_stream = 1'b0;
  logic               seg_valid;
  logic               seg_stall = 1'b0;
  logic signed [31:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
  int                 fail_count;
  int                 pending;

  // Stream bytes waiting to go out; bit 8 marks end of stream
  logic [8:0] stream_q[$];
  int         burst_left = 0;
  int         items_sent = 0;
  int         cycles = 0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;

  hpgl_line_command_parser_core dut (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .byte_in(byte_in), .end_of_stream(end_of_stream),
    .seg_valid(seg_valid), .seg_stall(seg_stall),
    .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
    .seg_end_x(seg_end_x), .seg_end_y(seg_end_y)
  );

  hpgl_line_command_parser_checker chk (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .byte_in(byte_in), .end_of_stream(end_of_stream),
    .seg_valid(seg_valid), .seg_stall(seg_stall),
    .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
    .seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] space_char(input int k);
    case (k)
      0:       return 8'h09;
      1:       return 8'h0A;
      2:       return 8'h0B;
      3:       return 8'h0C;
      4:       return 8'h0D;
      default: return " ";
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b);
    stream_q.push_back({1'b0, b});
  endtask

  task automatic put_end();
    stream_q.push_back({1'b1, 8'($urandom_range(0, 255))});
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_digits(input int n);
    repeat (n) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Append a number; a broken one is a bare sign, a bare dot, a signed dot or a random byte
  task automatic put_number(input bit clean);
    int pick, n_int, n_frac;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put_byte(space_char($urandom_range(0, 5)));
    if (!clean) begin
      case ($urandom_range(0, 3))
        0:       put_str("-");
        1:       put_str(".");
        2:       put_str("+.");
        default: put_byte(8'($urandom_range(0, 255)));
      endcase
      return;
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      // hit the saturation edges
      case ($urandom_range(0, 4))
        0:       put_str("2147483647");
        1:       put_str("-2147483648");
        2:       put_str("2147483647.5");
        3:       put_str("-2147483648.5");
        default: put_str("2147483648");
      endcase
      return;
    end
    case ($urandom_range(0, 3))
      0:       put_str("+");
      1:       put_str("-");
      default: ;
    endcase
    n_int = (pick == 1) ? $urandom_range(10, 12) : (pick == 2) ? 0 : $urandom_range(1, 4);
    if (n_int == 0) n_frac = $urandom_range(1, 3);
    else n_frac = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : -1;
    put_digits(n_int);
    if (n_frac >= 0) begin
      put_byte(CH_DOT);
      put_digits(n_frac);
    end
  endtask

  // Append a pen command with coordinate pairs and a terminator
  task automatic put_command(input cmd_e op, input int pairs);
    put_byte(CH_P);
    case (op)
      CMD_PA:  put_byte(CH_A);
      CMD_PR:  put_byte(CH_R);
      CMD_PU:  put_byte(CH_U);
      default: put_byte(CH_D);
    endcase
    for (int i = 0; i < pairs; i++) begin
      put_number($urandom_range(0, 24) != 0);
      if ($urandom_range(0, 19) == 0) put_byte(8'($urandom_range(0, 255)));
      else put_byte(CH_COMMA);
      put_number($urandom_range(0, 24) != 0);
      if (i < pairs - 1) begin
        case ($urandom_range(0, 9))
          0, 1:    put_byte(" ");
          2:       put_byte(8'($urandom_range(0, 255)));
          default: put_byte(CH_COMMA);
        endcase
      end
    end
    case ($urandom_range(0, 19))
      0:             put_end();
      1, 2, 3, 4, 5: put_byte(CH_NL);
      default:       put_byte(CH_SEMI);
    endcase
  endtask

  // Offer one byte, waiting out gaps between bursts and any stall
  task automatic send_item(input logic [8:0] item);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        byte_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    byte_valid    <= 1'b1;
    byte_in       <= item[7:0];
    end_of_stream <= item[8];
    do @(posedge clk); while (byte_stall);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic flush_stream();
    while (stream_q.size() != 0) send_item(stream_q.pop_front());
  endtask

  // Receiver: run each randomly chosen stall mode for a random stretch, hold off once on request
  initial begin : receiver
    rx_mode_e mode;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        @(negedge clk);
        seg_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        seg_stall <= 1'b0;
        hold_done = 1'b1;
      end else begin
        mode = rx_mode_e'($urandom_range(0, 3));
        repeat ($urandom_range(8, 60)) begin
          @(negedge clk);
          case (mode)
            RX_OPEN:  seg_stall <= 1'b0;
            RX_LIGHT: seg_stall <= ($urandom_range(0, 9) < 3);
            RX_HEAVY: seg_stall <= ($urandom_range(0, 9) < 8);
            default:  seg_stall <= ~seg_stall;
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int r;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: rounding of leading-dot fractions with pen down, newline cut
    // inside a token, SP discard, every command, byte extremes, end of stream
    put_str("PD.5,-.5\n");
    put_str("P\nA;");
    put_str("SP1;");
    put_str("PU;PA;PR;");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_SEMI);
    put_str("PD");
    put_end();
    flush_stream();

    // Long receiver hold-off while a dense pen-down command keeps coming
    hold_req = 1'b1;
    put_command(CMD_PD, 12);
    put_command(CMD_PD, 12);
    flush_stream();

    // Random: mostly well-formed commands, some noise and broken tokens
    while (items_sent < STREAM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 40) put_command(CMD_PD, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5));
      else if (r < 52) put_command(CMD_PA, $urandom_range(0, 4));
      else if (r < 64) put_command(CMD_PR, $urandom_range(0, 4));
      else if (r < 76) put_command(CMD_PU, $urandom_range(0, 3));
      else if (r < 84) begin
        repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
        put_byte(CH_SEMI);
      end else if (r < 90) begin
        put_str(($urandom_range(0, 1) == 0) ? "SP" : "XY");
        put_number(1'b1);
        put_byte(CH_SEMI);
      end else if (r < 94) begin
        put_str("P\nD1,1;");
      end else if (r < 97) begin
        put_str("pd1,2;");
      end else begin
        put_end();
      end
      flush_stream();
    end
    byte_valid <= 1'b0;

    // Drain outstanding segments, then give late extras time to show
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
